// ===== rtl/pmsc_pkg.sv =====
// Shared types, constants and helpers for the PID motor speed controller.
// Holds the microcode word layout used by the sequencer and the datapath.
// Depends on nothing; every other file of the block imports it.
package pmsc_pkg;

  // Encoder counter width and fraction bits of the gains.
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Datapath widths.
  localparam int SPEED_W  = 32;
  localparam int SUM_W    = 48;
  localparam int DERR_W   = SPEED_W + 1;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CHUNK_W  = 16;
  localparam int ACC_W    = 82;
  localparam int MAG_W    = FRAC_BITS + 9;
  localparam int PERIOD_W = 16;
  localparam int CMP_W    = 16;

  // Division by five, one hex digit per step.
  localparam int DIV_W     = 36;
  localparam int DIV_STEPS = DIV_W / 4;
  localparam int DIV_CNT_W = 4;

  // Microprogram size.
  localparam int STEP_W   = 5;
  localparam int PROG_LEN = 20;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REV_PERIOD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REV_ENABLE  = 3'd7;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_NOP,
    OP_SUM5,
    OP_DIV,
    OP_FILT,
    OP_ERR,
    OP_DERR,
    OP_PID,
    OP_CLAMP,
    OP_SCALE,
    OP_OUT
  } op_e;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MS_SPEED,
    MS_GAIN,
    MS_DUTY
  } mul_src_e;

  typedef enum logic [1:0] {
    G_P,
    G_I,
    G_D
  } gain_e;

  typedef enum logic [1:0] {
    X_ERR,
    X_SUM,
    X_DERR
  } opnd_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_LOOP,
    J_GOTO
  } jmp_e;

  typedef struct packed {
    op_e               op;
    logic              mul_en;
    mul_src_e          mul_src;
    gain_e             gain;
    opnd_e             opnd;
    logic [1:0]        chunk;
    logic              acc_en;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Status that steers the step counter.
  typedef struct packed {
    logic hold;
    logic loop_done;
  } seq_stat_t;

  // Quotient digit of x / 5 for x < 80: x * 205 / 1024 is exact there.
  function automatic logic [3:0] div5_digit(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[13:10];
  endfunction

endpackage

// ===== rtl/pmsc_seq.sv =====
// Microcode sequencer of the PID motor speed controller: step counter,
// control store and jump logic. Depends on pmsc_pkg.
module pmsc_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pmsc_pkg::seq_stat_t stat_i,
  output pmsc_pkg::ucode_t    ctrl_o
);
  import pmsc_pkg::*;

  localparam logic [STEP_W-1:0] STEP_WAIT = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_DIV  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_NONE = STEP_W'(0);

  // Fields: op, mul_en, mul_src, gain, opnd, chunk, acc_en, jmp, target.
  localparam ucode_t PROG [PROG_LEN] = '{
    '{OP_WAIT,  1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_NOP,   1'b1, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_SUM5,  1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_DIV,   1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_LOOP, STEP_DIV},
    '{OP_FILT,  1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_ERR,   1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_DERR,  1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_P, X_ERR,  2'd1, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_P, X_ERR,  2'd2, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_I, X_SUM,  2'd0, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_I, X_SUM,  2'd1, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_I, X_SUM,  2'd2, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_D, X_DERR, 2'd0, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_D, X_DERR, 2'd1, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b1, MS_GAIN,  G_D, X_DERR, 2'd2, 1'b1, J_NEXT, STEP_NONE},
    '{OP_PID,   1'b0, MS_GAIN,  G_P, X_ERR,  2'd0, 1'b1, J_NEXT, STEP_NONE},
    '{OP_CLAMP, 1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_SCALE, 1'b1, MS_DUTY,  G_P, X_ERR,  2'd0, 1'b0, J_NEXT, STEP_NONE},
    '{OP_OUT,   1'b0, MS_SPEED, G_P, X_ERR,  2'd0, 1'b0, J_GOTO, STEP_WAIT}
  };

  logic [STEP_W-1:0] step_q, step_d;

  assign ctrl_o = PROG[step_q];

  always_comb begin
    step_d = step_q;
    if (!stat_i.hold) begin
      case (ctrl_o.jmp)
        J_NEXT:  step_d = step_q + STEP_W'(1);
        J_LOOP:  step_d = stat_i.loop_done ? step_q + STEP_W'(1) : ctrl_o.target;
        J_GOTO:  step_d = ctrl_o.target;
        default: step_d = STEP_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  property p_step_in_program;
    @(posedge clk_i) disable iff (!rst_ni) step_q < STEP_W'(PROG_LEN);
  endproperty
  a_step_in_program: assert property (p_step_in_program)
    else $error("microcode step counter left the program");

  property p_hold_keeps_step;
    @(posedge clk_i) disable iff (!rst_ni) stat_i.hold |=> $stable(step_q);
  endproperty
  a_hold_keeps_step: assert property (p_hold_keeps_step)
    else $error("step counter moved while held");

  property p_out_returns;
    @(posedge clk_i) disable iff (!rst_ni)
      (ctrl_o.op == OP_OUT && !stat_i.hold) |=> step_q == STEP_WAIT;
  endproperty
  a_out_returns: assert property (p_out_returns)
    else $error("sequencer did not return to the wait step");

endmodule

// ===== rtl/pid_motor_speed_controller_top.sv =====
// PID motor speed controller: one encoder sample in, one PWM result out.
// Samples are taken only at the wait step, so a new sample waits until the
// previous tick is done; the tick is set by the single shared multiplier
// (11 products per tick) and the nine-step divide-by-five loop of the filter.
// The input side reopens while a result waits, so the output register hides
// downstream stalls up to one tick. Reset (rst_ni low, asynchronous) clears the
// controller state, config registers and result valid; ticks_per_second returns to 1.
module pid_motor_speed_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  // Encoder samples. tdata: [15:0] encoder_count.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,
  // Results. tdata: [15:0] fwd_compare, [31:16] rev_compare,
  // [63:32] smoothed_speed. tuser: [0] duty_clamped.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [63:0]                    m_axis_tdata,
  output logic                           m_axis_tuser
);
  import pmsc_pkg::*;

  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) << (FRAC_BITS + 8);
  localparam logic [MAG_W-1:0]        ONE_MAG = MAG_W'(1) << (FRAC_BITS + 8);
  localparam int                      RND_POS = FRAC_BITS + 8;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; each of the eight
  // indexes names one register.
  // ---------------------------------------------------------------------
  logic signed [31:0]   kp_q, ki_q, kd_q, target_q;
  logic [15:0]          tps_q;
  logic [PERIOD_W-1:0]  fwd_period_q, rev_period_q;
  logic                 rev_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q         <= '0;
      ki_q         <= '0;
      kd_q         <= '0;
      tps_q        <= 16'd1;
      target_q     <= '0;
      fwd_period_q <= '0;
      rev_period_q <= '0;
      rev_en_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PROP_GAIN:   kp_q         <= cfg_data_i;
        REG_INTEG_GAIN:  ki_q         <= cfg_data_i;
        REG_DERIV_GAIN:  kd_q         <= cfg_data_i;
        REG_TICKS_PER_S: tps_q        <= cfg_data_i[15:0];
        REG_TARGET:      target_q     <= cfg_data_i;
        REG_FWD_PERIOD:  fwd_period_q <= cfg_data_i[PERIOD_W-1:0];
        REG_REV_PERIOD:  rev_period_q <= cfg_data_i[PERIOD_W-1:0];
        REG_REV_ENABLE:  rev_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer. The control word of the current step drives everything
  // below; the step holds while waiting for a sample or for room in the
  // output register.
  // ---------------------------------------------------------------------
  ucode_t    ctrl;
  seq_stat_t stat;
  logic      in_xfer;
  logic      out_vld_q;

  logic [DIV_CNT_W-1:0] div_cnt_q;

  assign s_axis_tready = (ctrl.op == OP_WAIT);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign stat.hold      = (ctrl.op == OP_WAIT && !in_xfer) ||
                          (ctrl.op == OP_OUT && out_vld_q && !m_axis_tready);
  assign stat.loop_done = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  pmsc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // ---------------------------------------------------------------------
  // Controller state and scratch registers.
  // ---------------------------------------------------------------------
  logic [COUNT_BITS-1:0]     prev_q, diff_q;
  logic signed [SPEED_W-1:0] filt_q, prev_err_q, err_q;
  logic signed [SUM_W-1:0]   esum_q;
  logic signed [DERR_W-1:0]  derr_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]  mul_q;
  logic [1:0]                acc_sh_q;
  logic [DIV_W-1:0]          num_q, quot_q;
  logic [2:0]                rem_q;
  logic                      sneg_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      dneg_q, clamp_q;
  logic [CMP_W-1:0]          out_fwd_q, out_rev_q;
  logic [SPEED_W-1:0]        out_spd_q;
  logic                      out_clamp_q;

  // Shared multiplier: a signed 33-bit operand times a signed 17-bit one.
  // PID products use the gain times one 16-bit slice of a 48-bit operand;
  // the low slices are unsigned and the top slice carries the sign.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [31:0]        gain_sel;
  logic [SUM_W-1:0]          opnd;

  always_comb begin
    case (ctrl.gain)
      G_P:     gain_sel = kp_q;
      G_I:     gain_sel = ki_q;
      G_D:     gain_sel = kd_q;
      default: gain_sel = kp_q;
    endcase
    case (ctrl.opnd)
      X_ERR:   opnd = {{(SUM_W - SPEED_W){err_q[SPEED_W-1]}}, err_q};
      X_SUM:   opnd = esum_q;
      X_DERR:  opnd = {{(SUM_W - DERR_W){derr_q[DERR_W-1]}}, derr_q};
      default: opnd = esum_q;
    endcase
    case (ctrl.mul_src)
      MS_SPEED: begin
        mul_a = {{(MUL_A_W - COUNT_BITS){diff_q[COUNT_BITS-1]}}, diff_q};
        mul_b = {1'b0, tps_q};
      end
      MS_GAIN: begin
        mul_a = {gain_sel[31], gain_sel};
        case (ctrl.chunk)
          2'd0:    mul_b = {1'b0, opnd[CHUNK_W-1:0]};
          2'd1:    mul_b = {1'b0, opnd[2*CHUNK_W-1:CHUNK_W]};
          default: mul_b = {opnd[SUM_W-1], opnd[SUM_W-1:2*CHUNK_W]};
        endcase
      end
      MS_DUTY: begin
        mul_a = {{(MUL_A_W - MAG_W){1'b0}}, mag_q};
        mul_b = {1'b0, dneg_q ? rev_period_q : fwd_period_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Raw speed: difference times ticks per second, times 256, saturated to
  // 32 bits. The product saturates exactly when it leaves 24 signed bits.
  logic [SPEED_W-1:0] raw;
  always_comb begin
    if (mul_q[PROD_W-1:23] == '0 || mul_q[PROD_W-1:23] == '1) begin
      raw = {mul_q[23:0], 8'h00};
    end else if (mul_q[PROD_W-1]) begin
      raw = 32'h8000_0000;
    end else begin
      raw = 32'h7FFF_FFFF;
    end
  end

  // Filter numerator: |4*old + raw| + 2, divided by five and given back the
  // sign, which rounds to nearest with ties away from zero.
  logic signed [34:0] sum5;
  logic [34:0]        sum5_mag;
  assign sum5     = ($signed({{3{filt_q[SPEED_W-1]}}, filt_q}) <<< 2) +
                    $signed({{3{raw[SPEED_W-1]}}, raw});
  assign sum5_mag = sum5[34] ? 35'(-sum5) : 35'(sum5);

  logic [6:0] div_x;
  logic [3:0] div_q;
  logic [6:0] div_r;
  assign div_x = {rem_q, num_q[DIV_W-1:DIV_W-4]};
  assign div_q = div5_digit(div_x);
  assign div_r = div_x - 7'(div_q) * 7'd5;

  logic [SPEED_W-1:0] quot32;
  assign quot32 = quot_q[SPEED_W-1:0];

  // Error, saturated to 32 bits.
  logic signed [SPEED_W:0]   err_wide;
  logic signed [SPEED_W-1:0] err_sat;
  assign err_wide = $signed({target_q[SPEED_W-1], target_q}) -
                    $signed({filt_q[SPEED_W-1], filt_q});
  assign err_sat  = (err_wide[SPEED_W] == err_wide[SPEED_W-1]) ? err_wide[SPEED_W-1:0] :
                    (err_wide[SPEED_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // Integral, saturated to 48 bits.
  logic signed [SUM_W:0]   esum_wide;
  logic signed [SUM_W-1:0] esum_sat;
  assign esum_wide = $signed({esum_q[SUM_W-1], esum_q}) +
                     $signed({{(SUM_W + 1 - SPEED_W){err_q[SPEED_W-1]}}, err_q});
  assign esum_sat  = (esum_wide[SUM_W] == esum_wide[SUM_W-1]) ? esum_wide[SUM_W-1:0] :
                     (esum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                       : {1'b0, {(SUM_W - 1){1'b1}}});

  // Product placed at its slice position for the PID accumulator.
  logic signed [ACC_W-1:0] prod_ext, addend;
  assign prod_ext = {{(ACC_W - PROD_W){mul_q[PROD_W-1]}}, mul_q};
  always_comb begin
    case (acc_sh_q)
      2'd0:    addend = prod_ext;
      2'd1:    addend = prod_ext <<< CHUNK_W;
      default: addend = prod_ext <<< (2 * CHUNK_W);
    endcase
  end

  // Duty limit: a sum exactly at plus or minus one passes unclamped.
  logic                    pos_in, neg_in;
  logic signed [ACC_W-1:0] acc_neg;
  assign acc_neg = -acc_q;
  assign pos_in  = !acc_q[ACC_W-1] && (acc_q <= ONE_ACC);
  assign neg_in  = acc_q[ACC_W-1] && (acc_q >= -ONE_ACC);

  // Compare value: duty magnitude times period, rounded half up.
  logic [PROD_W-1:0] rnd;
  logic [CMP_W-1:0]  cmp;
  logic              mag_nz;
  assign rnd    = mul_q + (PROD_W'(1) << (RND_POS - 1));
  assign cmp    = rnd[RND_POS +: CMP_W];
  assign mag_nz = (mag_q != '0);

  // Controller state that reset clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      filt_q     <= '0;
      prev_err_q <= '0;
      esum_q     <= '0;
      div_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        prev_q <= s_axis_tdata[COUNT_BITS-1:0];
      end
      if (ctrl.op == OP_SUM5) begin
        div_cnt_q <= '0;
      end else if (ctrl.op == OP_DIV) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (ctrl.op == OP_FILT) begin
        filt_q <= sneg_q ? -$signed(quot32) : $signed(quot32);
      end
      if (ctrl.op == OP_DERR) begin
        prev_err_q <= err_q;
        esum_q     <= esum_sat;
      end
      if (ctrl.op == OP_OUT && !stat.hold) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working registers of one tick and the output register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      diff_q <= s_axis_tdata[COUNT_BITS-1:0] - prev_q;
    end
    if (ctrl.mul_en) begin
      mul_q    <= mul_a * mul_b;
      acc_sh_q <= ctrl.chunk;
    end
    if (ctrl.acc_en) begin
      acc_q <= acc_q + addend;
    end
    case (ctrl.op)
      OP_SUM5: begin
        num_q  <= DIV_W'(sum5_mag) + DIV_W'(2);
        quot_q <= '0;
        rem_q  <= '0;
        sneg_q <= sum5[34];
      end
      OP_DIV: begin
        num_q  <= num_q << 4;
        quot_q <= {quot_q[DIV_W-5:0], div_q};
        rem_q  <= div_r[2:0];
      end
      OP_ERR: begin
        err_q <= err_sat;
      end
      OP_DERR: begin
        derr_q <= $signed({prev_err_q[SPEED_W-1], prev_err_q}) -
                  $signed({err_q[SPEED_W-1], err_q});
        acc_q  <= '0;
      end
      OP_CLAMP: begin
        clamp_q <= !pos_in && !neg_in;
        if (pos_in) begin
          mag_q  <= acc_q[MAG_W-1:0];
          dneg_q <= 1'b0;
        end else if (neg_in) begin
          mag_q  <= acc_neg[MAG_W-1:0];
          dneg_q <= 1'b1;
        end else begin
          mag_q  <= ONE_MAG;
          dneg_q <= acc_q[ACC_W-1];
        end
      end
      OP_OUT: begin
        if (!stat.hold) begin
          out_fwd_q   <= (!dneg_q && mag_nz) ? cmp : '0;
          out_rev_q   <= (dneg_q && mag_nz && rev_en_q) ? cmp : '0;
          out_spd_q   <= filt_q;
          out_clamp_q <= clamp_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_spd_q, out_rev_q, out_fwd_q};
  assign m_axis_tuser  = out_clamp_q;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  property p_one_tick_at_a_time;
    @(posedge clk_i) disable iff (!rst_ni) in_xfer |=> !s_axis_tready;
  endproperty
  a_one_tick_at_a_time: assert property (p_one_tick_at_a_time)
    else $error("sample taken while a tick is in progress");

  property p_one_direction;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[15:0] == '0 || m_axis_tdata[31:16] == '0);
  endproperty
  a_one_direction: assert property (p_one_direction)
    else $error("both PWM directions driven at once");

  property p_duty_in_range;
    @(posedge clk_i) disable iff (!rst_ni) (ctrl.op == OP_SCALE) |-> mag_q <= ONE_MAG;
  endproperty
  a_duty_in_range: assert property (p_duty_in_range)
    else $error("duty magnitude above full scale");

  property p_div_count;
    @(posedge clk_i) disable iff (!rst_ni)
      (ctrl.op == OP_DIV) |-> div_cnt_q < DIV_CNT_W'(DIV_STEPS);
  endproperty
  a_div_count: assert property (p_div_count)
    else $error("divide loop ran past its last digit");

endmodule

// ===== dv/pid_motor_speed_controller_checker.sv =====
// Scoreboard for the PID motor speed controller: watches the config, sample and result
// channels, predicts each tick's PWM result and compares it field by field.
// Depends on pmsc_pkg for the register indexes and the fraction width.
module pid_motor_speed_controller_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           sample_valid_i,
  input  logic                           sample_ready_i,
  input  logic [15:0]                    sample_data_i,
  input  logic                           result_valid_i,
  input  logic                           result_ready_i,
  input  logic [63:0]                    result_data_i,
  input  logic                           result_user_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  import pmsc_pkg::*;

  localparam longint DUTY_ONE = longint'(1) <<< (FRAC_BITS + 8);

  typedef struct packed {
    logic [15:0] fwd;
    logic [15:0] rev;
    logic [31:0] speed;
    logic        clamped;
  } pwm_result_t;

  // Register copies.
  logic signed [31:0] kp, ki_dt, kd_over_dt, target;
  logic [15:0]        tps, fwd_per, rev_per;
  logic               rev_en;

  // Controller state.
  logic [15:0] last_count;
  longint      speed_filt, last_err, err_acc;

  pwm_result_t expected_q[$];
  int          mismatches = 0;
  int          outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = outstanding;

  function automatic longint clip(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic [15:0] scale_compare(input logic [63:0] mag, input logic [15:0] per);
    logic [63:0] t;
    t = (mag * per + (64'd1 << (FRAC_BITS + 7))) >> (FRAC_BITS + 8);
    return t[15:0];
  endfunction

  // One control tick: speed estimate, smoothing, PID sum, clamp and PWM split.
  function automatic pwm_result_t advance_tick(input logic [15:0] cnt);
    logic signed [15:0]  step;
    longint              raw, sum5, err, derr;
    logic signed [127:0] acc, wk, wx;
    logic [63:0]         mag;
    logic                neg;
    pwm_result_t         r;
    step       = cnt - last_count;
    last_count = cnt;
    raw        = clip(longint'(step) * longint'(tps) * 256, 32);
    sum5       = 4 * speed_filt + raw;
    speed_filt = (sum5 >= 0) ? (sum5 + 2) / 5 : -((-sum5 + 2) / 5);
    err        = clip(longint'(target) - speed_filt, 32);
    derr       = last_err - err;
    last_err   = err;
    err_acc    = clip(err_acc + err, 48);

    wk = kp;         wx = err;     acc = wk * wx;
    wk = ki_dt;      wx = err_acc; acc += wk * wx;
    wk = kd_over_dt; wx = derr;    acc += wk * wx;

    r.clamped = 1'b0;
    if (acc >= 0 && acc <= DUTY_ONE) begin
      mag = acc[63:0];
      neg = 1'b0;
    end else if (acc < 0 && acc >= -DUTY_ONE) begin
      wk  = -acc;
      mag = wk[63:0];
      neg = 1'b1;
    end else begin
      // Outside +-1.0: full scale in the direction of the sum.
      r.clamped = 1'b1;
      neg       = acc < 0;
      mag       = DUTY_ONE;
    end

    r.fwd   = (!neg && mag != 0) ? scale_compare(mag, fwd_per) : 16'd0;
    r.rev   = (neg && mag != 0 && rev_en) ? scale_compare(mag, rev_per) : 16'd0;
    r.speed = speed_filt[31:0];
    return r;
  endfunction

  task automatic log_mismatch(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pwm_result_t want, got;
    if (!rst_ni) begin
      kp         = '0;
      ki_dt      = '0;
      kd_over_dt = '0;
      target     = '0;
      tps        = 16'd1;
      fwd_per    = '0;
      rev_per    = '0;
      rev_en     = 1'b0;
      last_count = '0;
      speed_filt = 0;
      last_err   = 0;
      err_acc    = 0;
      expected_q.delete();
      outstanding = 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        got.fwd     = result_data_i[15:0];
        got.rev     = result_data_i[31:16];
        got.speed   = result_data_i[63:32];
        got.clamped = result_user_i;
        if (expected_q.size() == 0) begin
          log_mismatch("unexpected result", '0, result_data_i);
        end else begin
          want = expected_q.pop_front();
          if (got.fwd != want.fwd) log_mismatch("fwd_compare", want.fwd, got.fwd);
          if (got.rev != want.rev) log_mismatch("rev_compare", want.rev, got.rev);
          if (got.speed != want.speed)
            log_mismatch("smoothed_speed", want.speed, got.speed);
          if (got.clamped != want.clamped)
            log_mismatch("duty_clamped", want.clamped, got.clamped);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PROP_GAIN:   kp         = cfg_data_i;
          REG_INTEG_GAIN:  ki_dt      = cfg_data_i;
          REG_DERIV_GAIN:  kd_over_dt = cfg_data_i;
          REG_TICKS_PER_S: tps        = cfg_data_i[15:0];
          REG_TARGET:      target     = cfg_data_i;
          REG_FWD_PERIOD:  fwd_per    = cfg_data_i[15:0];
          REG_REV_PERIOD:  rev_per    = cfg_data_i[15:0];
          REG_REV_ENABLE:  rev_en     = cfg_data_i[0];
          default: ;
        endcase
      end
      if (sample_valid_i && sample_ready_i)
        expected_q.push_back(advance_tick(sample_data_i));
      outstanding = expected_q.size();
    end
  end

endmodule

// ===== dv/pid_motor_speed_controller_top_test.sv =====
// Testbench top for the PID motor speed controller: clock, reset, stimulus and verdict.
// Depends on pmsc_pkg, the block's top level and pid_motor_speed_controller_checker.
module pid_motor_speed_controller_top_test;
  import pmsc_pkg::*;

  // The watchdog limit leaves a wide margin over the slowest correct run.
  localparam int RUN_LIMIT    = 400000;
  // Drain time after the scoreboard empties, to catch any stray late output.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 125;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [31:0]          cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [63:0]          m_axis_tdata;
  logic                 m_axis_tuser;

  int          mismatch_count;
  int          pending;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          sink_hold     = 0;
  int          cycle_count   = 0;
  logic [15:0] enc_pos       = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_motor_speed_controller_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pid_motor_speed_controller_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .sample_valid_i   (s_axis_tvalid),
    .sample_ready_i   (s_axis_tready),
    .sample_data_i    (s_axis_tdata),
    .result_valid_i   (m_axis_tvalid),
    .result_ready_i   (m_axis_tready),
    .result_data_i    (m_axis_tdata),
    .result_user_i    (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Result side. The receiver is the only writer of tready. A long hold-off, requested by
  // the stimulus through sink_hold, is counted down here one cycle at a time; otherwise
  // tready drops at random according to the current idle percentage.
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready = 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready = ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("[pid_motor_speed_controller_top] ERROR");
      $finish;
    end
  end

  // One register write. It is only called while no sample is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one encoder sample, with random idle cycles in front of it. tvalid is written
  // once per falling edge, so it stays high without a glitch between back-to-back samples.
  // The task returns right after the rising edge at which the transfer happened.
  task automatic send_sample(input logic [15:0] cnt);
    @(negedge clk);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = cnt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop offering samples and wait until every expected result has been taken. Every
  // sample yields exactly one result, so an empty scoreboard means the block is idle.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Signed value with a roughly log-uniform magnitude, now and then an extreme. This
  // spreads the PID sum across the unclamped range as well as deep into saturation.
  function automatic logic [31:0] pick_signed();
    logic [31:0] v;
    case ($urandom_range(11, 0))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h0000_0000;
      default: begin
        v = $urandom & ((32'd1 << $urandom_range(31, 0)) - 1);
        if ($urandom_range(1, 0) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(5, 0))
      0:       return 32'd0;
      1:       return 32'd65535;
      default: return $urandom_range(65535, 0);
    endcase
  endfunction

  initial begin
    logic [15:0] velocity;
    velocity = '0;

    // Reset is released on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n         = 1'b1;
    src_idle_pct  = 13;
    sink_idle_pct = 66;

    // Reset settings: zero gains, one tick per second. A count that does not move keeps the
    // filtered speed at zero, which the exact-duty checks below depend on.
    send_sample(16'h0000);
    send_sample(16'h0000);
    wait_idle();

    // Exact full-scale duty. With kp = 1.0 and no speed (zero ticks per second forces the
    // raw speed to zero), an error of +1.0 gives a PID sum of exactly 1.0, which must not
    // count as clamped. Counts at both ends of the range still yield zero speed.
    write_reg(REG_PROP_GAIN, 32'h0001_0000);
    write_reg(REG_TICKS_PER_S, 32'd0);
    write_reg(REG_TARGET, 32'd256);
    write_reg(REG_FWD_PERIOD, 32'd1);
    write_reg(REG_REV_PERIOD, 32'd1);
    write_reg(REG_REV_ENABLE, 32'd1);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    wait_idle();
    write_reg(REG_TARGET, 32'hFFFF_FF00);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    // Half duty on a period of three: 1.5 must round up to 2, in both directions.
    wait_idle();
    write_reg(REG_TARGET, 32'd128);
    write_reg(REG_FWD_PERIOD, 32'd3);
    send_sample(16'h0001);
    wait_idle();
    write_reg(REG_TARGET, 32'hFFFF_FF80);
    write_reg(REG_REV_PERIOD, 32'd3);
    send_sample(16'h0001);
    // Reverse channel absent: the reverse compare must stay zero.
    wait_idle();
    write_reg(REG_REV_ENABLE, 32'd0);
    send_sample(16'h0001);

    // Just above 1.0 clamps; a zero period then gives a zero compare, the full period the
    // full compare value.
    wait_idle();
    write_reg(REG_TARGET, 32'd257);
    write_reg(REG_FWD_PERIOD, 32'd0);
    send_sample(16'h0001);
    wait_idle();
    write_reg(REG_FWD_PERIOD, 32'd65535);
    send_sample(16'h0001);

    // Saturation paths with extreme gains: maximal count steps at the largest tick rate
    // overflow the raw speed, and extreme targets overflow the error in both directions.
    wait_idle();
    write_reg(REG_TICKS_PER_S, 32'd65535);
    write_reg(REG_TARGET, 32'h8000_0000);
    write_reg(REG_PROP_GAIN, 32'h8000_0000);
    write_reg(REG_INTEG_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_DERIV_GAIN, 32'h8000_0000);
    write_reg(REG_REV_ENABLE, 32'd1);
    write_reg(REG_REV_PERIOD, 32'd65535);
    enc_pos = 16'h0001;
    repeat (3) begin
      enc_pos = enc_pos + 16'h7FFF;
      send_sample(enc_pos);
    end
    wait_idle();
    write_reg(REG_TARGET, 32'h7FFF_FFFF);
    repeat (3) begin
      enc_pos = enc_pos + 16'h8000;
      send_sample(enc_pos);
    end

    // Random part. Each phase starts from an idle block with fresh register values. The
    // encoder mostly moves like a motor at a steady rate with a little jitter; now and then
    // the count jumps to an arbitrary value.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p / 2)
        0:       begin src_idle_pct = 13; sink_idle_pct = 66; end
        1:       begin src_idle_pct = 66; sink_idle_pct = 13; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      write_reg(REG_PROP_GAIN, pick_signed());
      write_reg(REG_INTEG_GAIN, pick_signed());
      write_reg(REG_DERIV_GAIN, pick_signed());
      case ($urandom_range(5, 0))
        0:       write_reg(REG_TICKS_PER_S, 32'd0);
        1:       write_reg(REG_TICKS_PER_S, 32'd1);
        2:       write_reg(REG_TICKS_PER_S, 32'd65535);
        default: write_reg(REG_TICKS_PER_S,
                           $urandom_range((32'd1 << $urandom_range(16, 1)) - 1, 1));
      endcase
      write_reg(REG_TARGET, pick_signed());
      write_reg(REG_FWD_PERIOD, pick_period());
      write_reg(REG_REV_PERIOD, pick_period());
      write_reg(REG_REV_ENABLE, $urandom_range(1, 0));

      // With the sender running flat out, a long receiver hold-off fills the block and
      // must stall the sample side.
      if (p == 4) begin
        @(posedge clk);
        sink_hold = 400;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Mid-phase pause until everything in flight has come out.
        if (p == 2 && i == PHASE_ITEMS / 2) wait_idle();
        if (i % 20 == 0) begin
          velocity = $urandom_range(32'd1 << $urandom_range(14, 0), 0);
          if ($urandom_range(1, 0) == 1) velocity = -velocity;
        end
        if ($urandom_range(9, 0) == 0)
          enc_pos = $urandom;
        else
          enc_pos = enc_pos + velocity + 16'($urandom_range(2, 0)) - 16'd1;
        send_sample(enc_pos);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("[pid_motor_speed_controller_top] OK");
    end else begin
      $display("[pid_motor_speed_controller_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== pid_motor_speed_controller_top.f =====
rtl/pmsc_pkg.sv
rtl/pmsc_seq.sv
rtl/pid_motor_speed_controller_top.sv
dv/pid_motor_speed_controller_checker.sv
dv/pid_motor_speed_controller_top_test.sv
